>>> rtl/mstt_pkg.sv
// ----------------------------------------------------------------------------
// mstt_pkg: shared types and constants for the tick timer table
// Function codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package mstt_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int TICK_WIDTH_DEF = 8;

  localparam int FUNC_W   = 2;
  localparam int PERIOD_W = 8;
  localparam int REP_W    = 8;
  localparam int HANDLE_W = 6;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_SCHEDULE   = 2'd1,
    FUNC_CANCEL     = 2'd2,
    FUNC_CANCEL_ALL = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_SCAN,
    ST_TICK_EMIT,
    ST_SCHED_SCAN,
    ST_RESULT
  } state_t;

endpackage

>>> rtl/multi_slot_tick_timer_table.sv
// ----------------------------------------------------------------------------
// multi_slot_tick_timer_table: table of one-shot / periodic / counted timers
// Slot state lives in small memories swept by one shared decrement unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transfer:
//   tick, schedule, cancel one slot, or cancel all. Output channel
//   (out_valid / out_stall) returns result transfers; last marks the final
//   result of a command and any_active tells if any slot is busy afterward.
//   One command is in work at a time; in_stall is high until it completes.
//   Tick: the decrement unit sweeps all slots, one per cycle, through the
//   slot memories (one read port, one write port, registered read), then a
//   second sweep over the fired flags, stopping at the highest fired slot,
//   emits one result per fired slot in ascending order (or one status
//   result). Schedule: a sweep of the busy flags finds the lowest free
//   slot. Zero period, cancel and cancel-all skip the sweeps and go
//   straight to the result state.
//   A result sits in the output register while out_stall is high; the
//   sequencer waits for it to drain before loading the next one.
//   Reset clears all busy flags (every slot free) and the sequencer.
// ----------------------------------------------------------------------------
module multi_slot_tick_timer_table #(
  parameter int SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF,
  parameter int TICK_WIDTH = mstt_pkg::TICK_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mstt_pkg::FUNC_W-1:0]   func,
  input  logic [mstt_pkg::PERIOD_W-1:0] period_ticks,
  input  logic [mstt_pkg::REP_W-1:0]    repeat_count,
  input  logic [mstt_pkg::HANDLE_W-1:0] slot_handle,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mstt_pkg::HANDLE_W-1:0] slot,
  output logic                          fired,
  output logic                          error,
  output logic                          last,
  output logic                          any_active
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int PW    = (TICK_WIDTH > mstt_pkg::PERIOD_W) ? TICK_WIDTH : mstt_pkg::PERIOD_W;
  localparam logic [PW-1:0] TICK_MAX = PW'((64'd1 << TICK_WIDTH) - 64'd1);
  localparam logic [CNT_W-1:0] SLOTS = CNT_W'(SLOT_COUNT);

  // slot memories (busy flags in flops gate every read)
  logic [TICK_WIDTH-1:0]        slot_period       [SLOT_COUNT];
  logic [TICK_WIDTH-1:0]        slot_remaining    [SLOT_COUNT];
  logic [mstt_pkg::REP_W-1:0]   slot_repeats_left [SLOT_COUNT];

  mstt_pkg::state_t state, state_next;

  logic [CNT_W-1:0]            scan_cnt, scan_cnt_next;
  logic                        p_valid, p_valid_next;
  logic [IDX_W-1:0]            p_idx;
  logic [SLOT_COUNT-1:0]       busy, busy_next;
  logic [CNT_W-1:0]            busy_cnt, busy_cnt_next;
  logic [SLOT_COUNT-1:0]       fire_bits, fire_bits_next;
  logic                        any_fire, any_fire_next;
  logic [IDX_W-1:0]            last_fire_idx, last_fire_idx_next;
  logic [TICK_WIDTH-1:0]       req_period;
  logic [mstt_pkg::REP_W-1:0]  req_reps;
  logic [mstt_pkg::HANDLE_W-1:0] res_slot, res_slot_next;
  logic                        res_error, res_error_next;

  // registered memory read data
  logic [TICK_WIDTH-1:0]       rd_period, rd_rem;
  logic [mstt_pkg::REP_W-1:0]  rd_rep;
  logic [IDX_W-1:0]            rd_addr;

  // memory write port
  logic                        we_per, we_rem, we_rep;
  logic [IDX_W-1:0]            waddr;
  logic [TICK_WIDTH-1:0]       wd_per, wd_rem;
  logic [mstt_pkg::REP_W-1:0]  wd_rep;

  // output register load
  logic                        out_load, out_free;
  logic [mstt_pkg::HANDLE_W-1:0] slot_next;
  logic                        fired_next, error_next, last_next;

  logic                        in_xfer;
  logic [PW-1:0]               period_ext, period_satw;
  logic [TICK_WIDTH-1:0]       period_sat;
  logic                        handle_ok;
  logic [IDX_W-1:0]            handle_idx, scan_idx;

  assign in_stall = (state != mstt_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // period clipped to the counter range when the counter is narrow
  assign period_ext  = PW'(period_ticks);
  assign period_satw = (period_ext > TICK_MAX) ? TICK_MAX : period_ext;
  assign period_sat  = period_satw[TICK_WIDTH-1:0];

  assign handle_ok  = ({1'b0, slot_handle} < (mstt_pkg::HANDLE_W+1)'(SLOT_COUNT));
  assign handle_idx = IDX_W'(slot_handle);
  assign scan_idx   = scan_cnt[IDX_W-1:0];
  assign rd_addr    = scan_idx;

  // sequencer: next state, table updates, result loading
  always_comb begin
    state_next         = state;
    scan_cnt_next      = scan_cnt;
    p_valid_next       = 1'b0;
    busy_next          = busy;
    busy_cnt_next      = busy_cnt;
    fire_bits_next     = fire_bits;
    any_fire_next      = any_fire;
    last_fire_idx_next = last_fire_idx;
    res_slot_next      = res_slot;
    res_error_next     = res_error;
    we_per             = 1'b0;
    we_rem             = 1'b0;
    we_rep             = 1'b0;
    waddr              = p_idx;
    wd_per             = req_period;
    wd_rem             = req_period;
    wd_rep             = req_reps;
    out_load           = 1'b0;
    slot_next          = res_slot;
    fired_next         = 1'b0;
    error_next         = res_error;
    last_next          = 1'b1;

    case (state)
      mstt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (mstt_pkg::func_t'(func))
            mstt_pkg::FUNC_TICK: begin
              scan_cnt_next  = '0;
              fire_bits_next = '0;
              any_fire_next  = 1'b0;
              state_next     = mstt_pkg::ST_TICK_SCAN;
            end
            mstt_pkg::FUNC_SCHEDULE: begin
              if (period_sat == '0) begin
                res_slot_next  = '0;
                res_error_next = 1'b1;
                state_next     = mstt_pkg::ST_RESULT;
              end else begin
                scan_cnt_next = '0;
                state_next    = mstt_pkg::ST_SCHED_SCAN;
              end
            end
            mstt_pkg::FUNC_CANCEL: begin
              if (handle_ok && busy[handle_idx]) begin
                busy_next[handle_idx] = 1'b0;
                busy_cnt_next         = busy_cnt - 1'b1;
              end
              res_slot_next  = slot_handle;
              res_error_next = 1'b0;
              state_next     = mstt_pkg::ST_RESULT;
            end
            default: begin  // cancel all
              busy_next      = '0;
              busy_cnt_next  = '0;
              res_slot_next  = '0;
              res_error_next = 1'b0;
              state_next     = mstt_pkg::ST_RESULT;
            end
          endcase
        end
      end

      mstt_pkg::ST_TICK_SCAN: begin
        // issue stage: one memory read per cycle
        if (scan_cnt < SLOTS) begin
          p_valid_next  = 1'b1;
          scan_cnt_next = scan_cnt + 1'b1;
        end
        // update stage: shared decrement / reload unit
        if (p_valid && busy[p_idx]) begin
          if (rd_rem > TICK_WIDTH'(1)) begin
            we_rem = 1'b1;
            wd_rem = rd_rem - 1'b1;
          end else begin
            fire_bits_next[p_idx] = 1'b1;
            any_fire_next         = 1'b1;
            last_fire_idx_next    = p_idx;
            if (rd_rep == mstt_pkg::REP_W'(1)) begin
              busy_next[p_idx] = 1'b0;
              busy_cnt_next    = busy_cnt - 1'b1;
            end else begin
              we_rem = 1'b1;
              wd_rem = rd_period;
              we_rep = 1'b1;
              wd_rep = (rd_rep != '0) ? rd_rep - 1'b1 : rd_rep;
            end
          end
        end
        if (!(scan_cnt < SLOTS) && !p_valid) begin
          scan_cnt_next = '0;
          state_next    = mstt_pkg::ST_TICK_EMIT;
        end
      end

      mstt_pkg::ST_TICK_EMIT: begin
        if (!any_fire) begin
          // nothing fired: single status result
          if (out_free) begin
            out_load   = 1'b1;
            slot_next  = '0;
            error_next = 1'b0;
            state_next = mstt_pkg::ST_IDLE;
          end
        end else if (fire_bits[scan_idx]) begin
          if (out_free) begin
            out_load   = 1'b1;
            slot_next  = mstt_pkg::HANDLE_W'(scan_idx);
            fired_next = 1'b1;
            error_next = 1'b0;
            last_next  = (scan_idx == last_fire_idx);
            if (scan_idx == last_fire_idx) begin
              state_next = mstt_pkg::ST_IDLE;
            end else begin
              scan_cnt_next = scan_cnt + 1'b1;
            end
          end
        end else begin
          scan_cnt_next = scan_cnt + 1'b1;
        end
      end

      mstt_pkg::ST_SCHED_SCAN: begin
        if (scan_cnt < SLOTS) begin
          if (!busy[scan_idx]) begin
            we_per                  = 1'b1;
            we_rem                  = 1'b1;
            we_rep                  = 1'b1;
            waddr                   = scan_idx;
            busy_next[scan_idx]     = 1'b1;
            busy_cnt_next           = busy_cnt + 1'b1;
            res_slot_next           = mstt_pkg::HANDLE_W'(scan_idx);
            res_error_next          = 1'b0;
            state_next              = mstt_pkg::ST_RESULT;
          end else begin
            scan_cnt_next = scan_cnt + 1'b1;
          end
        end else begin
          // table full
          res_slot_next  = '0;
          res_error_next = 1'b1;
          state_next     = mstt_pkg::ST_RESULT;
        end
      end

      mstt_pkg::ST_RESULT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = mstt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = mstt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mstt_pkg::ST_IDLE;
      scan_cnt <= '0;
      p_valid  <= 1'b0;
      busy     <= '0;
      busy_cnt <= '0;
      any_fire <= 1'b0;
    end else begin
      state    <= state_next;
      scan_cnt <= scan_cnt_next;
      p_valid  <= p_valid_next;
      busy     <= busy_next;
      busy_cnt <= busy_cnt_next;
      any_fire <= any_fire_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fire_bits     <= fire_bits_next;
    last_fire_idx <= last_fire_idx_next;
    res_slot      <= res_slot_next;
    res_error     <= res_error_next;
    p_idx         <= rd_addr;
    if (in_xfer) begin
      req_period <= period_sat;
      req_reps   <= repeat_count;
    end
  end

  // slot memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we_per) begin
      slot_period[waddr] <= wd_per;
    end
    if (we_rem) begin
      slot_remaining[waddr] <= wd_rem;
    end
    if (we_rep) begin
      slot_repeats_left[waddr] <= wd_rep;
    end
    rd_period <= slot_period[rd_addr];
    rd_rem    <= slot_remaining[rd_addr];
    rd_rep    <= slot_repeats_left[rd_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      slot       <= slot_next;
      fired      <= fired_next;
      error      <= error_next;
      last       <= last_next;
      any_active <= (busy_cnt != '0);
    end
  end

endmodule

>>> sim/multi_slot_tick_timer_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_tick_timer_table_test: self-checking bench for the timer table
// Drives tick, schedule, cancel and cancel-all commands with random gaps,
// predicts every result transfer from a local copy of the slot table, and
// compares each returned result field by field under random output stalls.
// ----------------------------------------------------------------------------
module multi_slot_tick_timer_table_test;

  localparam int NSLOTS = mstt_pkg::SLOT_COUNT_DEF;
  localparam int IDX_W  = $clog2(NSLOTS);
  // one tick sweeps the table twice; used for the settle time at the end
  localparam int SWEEP_CYCLES = 2 * NSLOTS + 8;

  typedef struct packed {
    logic [mstt_pkg::HANDLE_W-1:0] slot;
    logic                          fired;
    logic                          error;
    logic                          last;
    logic                          any_active;
  } timer_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [mstt_pkg::FUNC_W-1:0]   func = mstt_pkg::FUNC_TICK;
  logic [mstt_pkg::PERIOD_W-1:0] period_ticks = '0;
  logic [mstt_pkg::REP_W-1:0]    repeat_count = '0;
  logic [mstt_pkg::HANDLE_W-1:0] slot_handle = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [mstt_pkg::HANDLE_W-1:0] slot;
  logic                          fired;
  logic                          error;
  logic                          last;
  logic                          any_active;

  multi_slot_tick_timer_table dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .period_ticks(period_ticks),
    .repeat_count(repeat_count),
    .slot_handle (slot_handle),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .slot        (slot),
    .fired       (fired),
    .error       (error),
    .last        (last),
    .any_active  (any_active)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the slot table. A zero period marks a free slot; the
  // countdown and repeat entries are only read while the slot is busy.
  logic [mstt_pkg::PERIOD_W-1:0] timer_period [NSLOTS];
  logic [mstt_pkg::PERIOD_W-1:0] timer_left   [NSLOTS];
  logic [mstt_pkg::REP_W-1:0]    timer_reps   [NSLOTS];

  timer_result_t due_results [$];   // results still owed by the block
  timer_result_t got_want;
  int            errors = 0;
  int unsigned   gap_pct = 0;       // chance of an input gap burst per command
  int unsigned   stall_pct = 0;     // chance per cycle of starting an output stall burst
  int unsigned   stall_run = 0;

  function automatic int busy_slots();
    int n;
    n = 0;
    for (int i = 0; i < NSLOTS; i++) begin
      if (timer_period[i] != '0) n++;
    end
    return n;
  endfunction

  // Apply one accepted command to the local table and queue its results.
  task automatic advance_timer_table(mstt_pkg::func_t f,
                                     logic [mstt_pkg::PERIOD_W-1:0] per,
                                     logic [mstt_pkg::REP_W-1:0] reps,
                                     logic [mstt_pkg::HANDLE_W-1:0] hdl);
    timer_result_t step_res [$];
    int            free_idx;
    logic          still_busy;
    free_idx = -1;
    case (f)
      mstt_pkg::FUNC_TICK: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (timer_period[i] != '0) begin
            if (timer_left[i] > 1) begin
              timer_left[i] = timer_left[i] - 1'b1;
            end else begin
              step_res.push_back('{slot: mstt_pkg::HANDLE_W'(i), fired: 1'b1,
                                   error: 1'b0, last: 1'b0, any_active: 1'b0});
              // one-shot (or final counted firing) frees the slot
              if (timer_reps[i] == 1) begin
                timer_period[i] = '0;
              end else begin
                if (timer_reps[i] != 0) timer_reps[i] = timer_reps[i] - 1'b1;
                timer_left[i] = timer_period[i];
              end
            end
          end
        end
        // nothing fired: a single status result
        if (step_res.size() == 0) step_res.push_back('0);
      end
      mstt_pkg::FUNC_SCHEDULE: begin
        if (per != '0) begin
          for (int i = NSLOTS - 1; i >= 0; i--) begin
            if (timer_period[i] == '0) free_idx = i;
          end
        end
        if (free_idx >= 0) begin
          timer_period[IDX_W'(free_idx)] = per;
          timer_left[IDX_W'(free_idx)]   = per;
          timer_reps[IDX_W'(free_idx)]   = reps;
          step_res.push_back('{slot: mstt_pkg::HANDLE_W'(free_idx), fired: 1'b0,
                               error: 1'b0, last: 1'b0, any_active: 1'b0});
        end else begin
          // zero period or table full
          step_res.push_back('{slot: '0, fired: 1'b0, error: 1'b1,
                               last: 1'b0, any_active: 1'b0});
        end
      end
      mstt_pkg::FUNC_CANCEL: begin
        // out-of-range handles are ignored but still echoed
        if (hdl < NSLOTS) timer_period[hdl[IDX_W-1:0]] = '0;
        step_res.push_back('{slot: hdl, fired: 1'b0, error: 1'b0,
                             last: 1'b0, any_active: 1'b0});
      end
      default: begin
        for (int i = 0; i < NSLOTS; i++) timer_period[i] = '0;
        step_res.push_back('0);
      end
    endcase
    still_busy = (busy_slots() != 0);
    foreach (step_res[k]) begin
      step_res[k].any_active = still_busy;
      step_res[k].last       = (k == step_res.size() - 1);
      due_results.push_back(step_res[k]);
    end
  endtask

  // Present one command at a falling edge and hold it until the transfer.
  task automatic issue_command(mstt_pkg::func_t f,
                               logic [mstt_pkg::PERIOD_W-1:0] per,
                               logic [mstt_pkg::REP_W-1:0] reps,
                               logic [mstt_pkg::HANDLE_W-1:0] hdl);
    @(negedge clk);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    period_ticks <= per;
    repeat_count <= reps;
    slot_handle  <= hdl;
    do @(posedge clk); while (in_stall);
    advance_timer_table(f, per, reps, hdl);
  endtask

  // Output side: random stall bursts.
  always @(negedge clk) begin
    if (stall_run != 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("result with nothing expected: slot %0d fired %0d", slot, fired);
        errors++;
      end else begin
        got_want = due_results.pop_front();
        check_field("slot", 8'(got_want.slot), 8'(slot));
        check_field("fired", 8'(got_want.fired), 8'(fired));
        check_field("error", 8'(got_want.error), 8'(error));
        check_field("last", 8'(got_want.last), 8'(last));
        check_field("any_active", 8'(got_want.any_active), 8'(any_active));
      end
    end
  end

  // Empty table: status tick, rejected zero period, cancel-all on nothing.
  task automatic test_empty_table();
    issue_command(mstt_pkg::FUNC_TICK, 8'hFF, 8'hFF, 6'h3F);
    issue_command(mstt_pkg::FUNC_SCHEDULE, 8'd0, 8'd1, 6'd0);
    issue_command(mstt_pkg::FUNC_CANCEL_ALL, 8'd0, 8'd0, 6'd0);
  endtask

  // One-shot, forever, counted and extreme period/count; then let them run.
  task automatic test_schedule_modes();
    issue_command(mstt_pkg::FUNC_SCHEDULE, 8'd1, 8'd1, 6'd0);
    issue_command(mstt_pkg::FUNC_SCHEDULE, 8'd2, 8'd0, 6'd0);
    issue_command(mstt_pkg::FUNC_SCHEDULE, 8'd1, 8'd3, 6'd0);
    issue_command(mstt_pkg::FUNC_SCHEDULE, 8'hFF, 8'hFF, 6'h3F);
    repeat (4) issue_command(mstt_pkg::FUNC_TICK, 8'd0, 8'd0, 6'd0);
  endtask

  // Cancel busy, already free and out-of-range slots; slot reuse after it.
  task automatic test_cancel_cases();
    issue_command(mstt_pkg::FUNC_CANCEL, 8'd0, 8'd0, 6'd1);
    issue_command(mstt_pkg::FUNC_CANCEL, 8'd0, 8'd0, 6'd1);
    issue_command(mstt_pkg::FUNC_CANCEL, 8'd0, 8'd0, 6'h3F);
    issue_command(mstt_pkg::FUNC_CANCEL, 8'd0, 8'd0, 6'd32);
    issue_command(mstt_pkg::FUNC_SCHEDULE, 8'd3, 8'd2, 6'd0);
    repeat (3) issue_command(mstt_pkg::FUNC_TICK, 8'd0, 8'd0, 6'd0);
    issue_command(mstt_pkg::FUNC_CANCEL_ALL, 8'hFF, 8'hFF, 6'h3F);
    issue_command(mstt_pkg::FUNC_TICK, 8'd0, 8'd0, 6'd0);
  endtask

  // Mixed traffic; mostly short periods and small counts so slots keep firing.
  task automatic test_random_traffic(int n);
    int unsigned                   pick;
    logic [mstt_pkg::PERIOD_W-1:0] per;
    logic [mstt_pkg::REP_W-1:0]    reps;
    logic [mstt_pkg::HANDLE_W-1:0] hdl;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      per  = mstt_pkg::PERIOD_W'(($urandom_range(0, 19) == 0) ?
                                 $urandom_range(0, 255) : $urandom_range(1, 6));
      if ($urandom_range(0, 39) == 0) per = '0;
      reps = mstt_pkg::REP_W'(($urandom_range(0, 9) == 0) ?
                              $urandom_range(0, 255) : $urandom_range(0, 4));
      hdl  = mstt_pkg::HANDLE_W'(($urandom_range(0, 4) == 0) ?
                                 $urandom_range(0, 63) : $urandom_range(0, NSLOTS - 1));
      if (pick < 45) begin
        issue_command(mstt_pkg::FUNC_TICK, per, reps, hdl);
      end else if (pick < 75) begin
        issue_command(mstt_pkg::FUNC_SCHEDULE, per, reps, hdl);
      end else if (pick < 96) begin
        issue_command(mstt_pkg::FUNC_CANCEL, per, reps, hdl);
      end else begin
        issue_command(mstt_pkg::FUNC_CANCEL_ALL, per, reps, hdl);
      end
    end
  endtask

  // Fill every free slot with period 1, bounce off the full table, then fire
  // the period-1 slots together on one tick for a wide burst of results.
  task automatic test_table_full();
    while (busy_slots() < NSLOTS) begin
      issue_command(mstt_pkg::FUNC_SCHEDULE, 8'd1,
                    mstt_pkg::REP_W'($urandom_range(0, 3)),
                    mstt_pkg::HANDLE_W'($urandom_range(0, 63)));
    end
    issue_command(mstt_pkg::FUNC_SCHEDULE, 8'd5, 8'd0, 6'd0);
    issue_command(mstt_pkg::FUNC_SCHEDULE, 8'd0, 8'd0, 6'd0);
    repeat (2) issue_command(mstt_pkg::FUNC_TICK, 8'd0, 8'd0, 6'd0);
    issue_command(mstt_pkg::FUNC_CANCEL_ALL, 8'd0, 8'd0, 6'd0);
  endtask

  initial begin
    for (int i = 0; i < NSLOTS; i++) timer_period[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    gap_pct   = 30;
    stall_pct = 15;
    test_empty_table();
    test_schedule_modes();
    test_cancel_cases();

    // alternate busy and quiet handshake phases
    test_random_traffic(100);
    gap_pct   = 0;
    stall_pct = 0;
    test_random_traffic(60);
    gap_pct   = 50;
    stall_pct = 30;
    test_random_traffic(100);
    test_table_full();
    gap_pct   = 20;
    stall_pct = 10;
    test_random_traffic(100);

    // tail of the run without any idling
    gap_pct   = 0;
    stall_pct = 0;
    test_random_traffic(50);

    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SWEEP_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #(10_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
